/* rtl/core/bmf_pkg.sv */
package bmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_WINDOW = 11;
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_SLOTS  = MAX_WINDOW + 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SLOT_W     = $clog2(ROW_SLOTS);
    localparam int RAM_DEPTH  = ROW_SLOTS * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);
    localparam int SUM_W      = 15;
    localparam int CNT_W      = 7;
    localparam int RAD_W      = 3;
    localparam int SIDE_W     = 4;
    localparam int DIV_STEPS  = SUM_W;

    // register indexes
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic cap;
        logic wr;
        logic start;
        logic step;
        logic div_init;
        logic div_step;
        logic load_out;
    } bmf_cmd_t;

    typedef struct packed {
        logic ready;
        logic sum_last;
        logic div_last;
        logic out_free;
    } bmf_stat_t;

endpackage

/* rtl/core/bmf_ram.sv */
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/bmf_ctrl.sv */
module bmf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bmf_pkg::bmf_stat_t stat,
    output bmf_pkg::bmf_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_WRITE = 8'b0000_0010,
        ST_CHECK = 8'b0000_0100,
        ST_SUM   = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_DIVI  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_PUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.wr     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.ready)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                cmd.step = 1'b1;
                if (stat.sum_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DIVI;
            end
            ST_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/bmf_dp.sv */
module bmf_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  bmf_pkg::bmf_cmd_t  cmd,
    output bmf_pkg::bmf_stat_t stat,
    input  logic               in_action,
    input  logic [7:0]         in_pixel,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_mean,
    output logic               out_last
);

    localparam logic [bmf_pkg::SLOT_W-1:0] SLOT_MAX = bmf_pkg::SLOT_W'(bmf_pkg::ROW_SLOTS - 1);
    localparam logic [bmf_pkg::SLOT_W-1:0] SLOTS    = bmf_pkg::SLOT_W'(bmf_pkg::ROW_SLOTS);

    logic [3:0]  win_reg;
    logic [10:0] wid_reg;
    logic [12:0] hgt_reg;

    logic [bmf_pkg::COL_W-1:0]  in_col_reg, out_col_reg;
    logic [bmf_pkg::ROW_W-1:0]  in_row_reg, out_row_reg;
    logic [bmf_pkg::SLOT_W-1:0] in_slot_reg, out_slot_reg;
    logic                       in_done_reg;

    logic                       act_reg;
    logic [7:0]                 pix_reg;

    logic [bmf_pkg::SLOT_W-1:0] rs_reg;
    logic [bmf_pkg::SIDE_W-1:0] rows_left_reg;
    logic [bmf_pkg::COL_W-1:0]  cc_reg, c0_reg, c1_reg;
    logic                       rd_valid_reg;
    logic [bmf_pkg::SUM_W-1:0]  total_reg;
    logic [bmf_pkg::CNT_W-1:0]  count_reg;

    logic [bmf_pkg::SUM_W-1:0]  quo_reg;
    logic [bmf_pkg::CNT_W-1:0]  rem_reg;
    logic [3:0]                 dstep_reg;

    logic                       m_valid_reg;
    logic [7:0]                 m_mean_reg;
    logic                       m_last_reg;

    // effective configuration
    logic [3:0]                 win_eff;
    logic [bmf_pkg::RAD_W-1:0]  rad;
    logic [10:0]                wid_eff;
    logic [12:0]                hgt_eff;
    logic [10:0]                wid_m1;
    logic [12:0]                hgt_m1;

    always_comb
    begin
        win_eff = win_reg;
        if (win_eff == 4'd0)
        begin
            win_eff = 4'd1;
        end
        else if (win_eff > 4'(bmf_pkg::MAX_WINDOW))
        begin
            win_eff = 4'(bmf_pkg::MAX_WINDOW);
        end
        rad = bmf_pkg::RAD_W'((win_eff - 4'd1) >> 1);
        wid_eff = wid_reg;
        if (wid_eff == 11'd0)
        begin
            wid_eff = 11'd1;
        end
        else if (wid_eff > 11'(bmf_pkg::MAX_WIDTH))
        begin
            wid_eff = 11'(bmf_pkg::MAX_WIDTH);
        end
        hgt_eff = hgt_reg;
        if (hgt_eff == 13'd0)
        begin
            hgt_eff = 13'd1;
        end
        else if (hgt_eff > 13'(bmf_pkg::MAX_HEIGHT))
        begin
            hgt_eff = 13'(bmf_pkg::MAX_HEIGHT);
        end
        wid_m1 = wid_eff - 11'd1;
        hgt_m1 = hgt_eff - 13'd1;
    end

    // readiness of the next result
    logic [12:0] need_r_sum, need_r;
    logic [10:0] need_c_sum, need_c;
    logic [12:0] r0;
    logic [10:0] c0;
    logic        ready_now;

    always_comb
    begin
        need_r_sum = {1'b0, out_row_reg} + 13'(rad);
        need_r     = (need_r_sum > hgt_m1) ? hgt_m1 : need_r_sum;
        need_c_sum = {1'b0, out_col_reg} + 11'(rad);
        need_c     = (need_c_sum > wid_m1) ? wid_m1 : need_c_sum;
        r0 = ({1'b0, out_row_reg} >= 13'(rad)) ? ({1'b0, out_row_reg} - 13'(rad)) : 13'd0;
        c0 = ({1'b0, out_col_reg} >= 11'(rad)) ? ({1'b0, out_col_reg} - 11'(rad)) : 11'd0;
        ready_now = in_done_reg || ({1'b0, in_row_reg} > need_r)
                    || (({1'b0, in_row_reg} == need_r) && ({1'b0, in_col_reg} > need_c));
    end

    // slot of the top window row
    logic [bmf_pkg::SLOT_W-1:0] r0_slot;
    logic [bmf_pkg::SIDE_W-1:0] rows_m1, cols_m1;

    always_comb
    begin
        if ({1'b0, out_row_reg} < 13'(rad))
        begin
            r0_slot = '0;
        end
        else if (out_slot_reg >= bmf_pkg::SLOT_W'(rad))
        begin
            r0_slot = out_slot_reg - bmf_pkg::SLOT_W'(rad);
        end
        else
        begin
            r0_slot = out_slot_reg + SLOTS - bmf_pkg::SLOT_W'(rad);
        end
        rows_m1 = bmf_pkg::SIDE_W'(need_r - r0);
        cols_m1 = bmf_pkg::SIDE_W'(need_c - c0);
    end

    // line store
    logic [bmf_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]                 rd_data;
    logic                       ram_we;

    assign ram_we  = cmd.wr && !act_reg && !in_done_reg;
    assign wr_addr = {in_slot_reg, in_col_reg};
    assign rd_addr = {rs_reg, cc_reg};

    bmf_ram #(
        .WIDTH (8),
        .DEPTH (bmf_pkg::RAM_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (pix_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic       frame_end;
    logic [7:0] trial;
    logic       cfg_hit;

    assign frame_end = ({1'b0, out_row_reg} == hgt_m1) && ({1'b0, out_col_reg} == wid_m1);
    assign trial     = {rem_reg, quo_reg[bmf_pkg::SUM_W-1]};
    // write to a known register
    assign cfg_hit   = cfg_wr_en && (cfg_index == bmf_pkg::REG_WINDOW
                                     || cfg_index == bmf_pkg::REG_WIDTH
                                     || cfg_index == bmf_pkg::REG_HEIGHT);

    // position counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= 4'd3;
            wid_reg      <= 11'd640;
            hgt_reg      <= 13'd480;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            in_done_reg  <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.step;
            if (cmd.load_out && !cfg_hit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_hit)
            begin
                unique case (cfg_index)
                    bmf_pkg::REG_WINDOW: win_reg <= cfg_data[3:0];
                    bmf_pkg::REG_WIDTH:  wid_reg <= cfg_data[10:0];
                    bmf_pkg::REG_HEIGHT: hgt_reg <= cfg_data;
                    default:             win_reg <= win_reg;
                endcase
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_slot_reg  <= '0;
                in_done_reg  <= 1'b0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_slot_reg <= '0;
            end
            else
            begin
                if (ram_we)
                begin
                    if ({1'b0, in_col_reg} == wid_m1)
                    begin
                        in_col_reg <= '0;
                        if ({1'b0, in_row_reg} == hgt_m1)
                        begin
                            in_done_reg <= 1'b1;
                        end
                        else
                        begin
                            in_row_reg  <= in_row_reg + 1'b1;
                            in_slot_reg <= (in_slot_reg == SLOT_MAX) ? '0 : in_slot_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end
                end
                if (cmd.load_out)
                begin
                    if (frame_end)
                    begin
                        in_col_reg   <= '0;
                        in_row_reg   <= '0;
                        in_slot_reg  <= '0;
                        in_done_reg  <= 1'b0;
                        out_col_reg  <= '0;
                        out_row_reg  <= '0;
                        out_slot_reg <= '0;
                    end
                    else if ({1'b0, out_col_reg} == wid_m1)
                    begin
                        out_col_reg  <= '0;
                        out_row_reg  <= out_row_reg + 1'b1;
                        out_slot_reg <= (out_slot_reg == SLOT_MAX) ? '0 : out_slot_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    // window walk, sum and divider
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            act_reg <= in_action;
            pix_reg <= in_pixel;
        end
        if (cmd.start)
        begin
            rs_reg        <= r0_slot;
            rows_left_reg <= rows_m1;
            cc_reg        <= bmf_pkg::COL_W'(c0);
            c0_reg        <= bmf_pkg::COL_W'(c0);
            c1_reg        <= bmf_pkg::COL_W'(need_c);
            count_reg     <= bmf_pkg::CNT_W'(rows_m1 + 4'd1) * bmf_pkg::CNT_W'(cols_m1 + 4'd1);
            total_reg     <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                if (cc_reg == c1_reg)
                begin
                    cc_reg        <= c0_reg;
                    rs_reg        <= (rs_reg == SLOT_MAX) ? '0 : rs_reg + 1'b1;
                    rows_left_reg <= rows_left_reg - 1'b1;
                end
                else
                begin
                    cc_reg <= cc_reg + 1'b1;
                end
            end
            if (rd_valid_reg)
            begin
                total_reg <= total_reg + bmf_pkg::SUM_W'(rd_data);
            end
        end
        if (cmd.div_init)
        begin
            quo_reg   <= total_reg;
            rem_reg   <= '0;
            dstep_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dstep_reg <= dstep_reg + 1'b1;
            if (trial >= {1'b0, count_reg})
            begin
                rem_reg <= bmf_pkg::CNT_W'(trial - {1'b0, count_reg});
                quo_reg <= {quo_reg[bmf_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[bmf_pkg::CNT_W-1:0];
                quo_reg <= {quo_reg[bmf_pkg::SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.load_out)
        begin
            m_mean_reg <= quo_reg[7:0];
            m_last_reg <= frame_end;
        end
    end

    assign stat.ready    = ready_now;
    assign stat.sum_last = (cc_reg == c1_reg) && (rows_left_reg == '0);
    assign stat.div_last = (dstep_reg == 4'(bmf_pkg::DIV_STEPS - 1));
    assign stat.out_free = !m_valid_reg || out_ready;

    assign out_valid = m_valid_reg;
    assign out_mean  = m_mean_reg;
    assign out_last  = m_last_reg;

endmodule

/* rtl/core/box_mean_filter.sv */
// box mean filter: takes 8-bit grey pixels in raster order and returns, for each
// pixel, the floor of the mean over the square window centred on it, clipped at
// the image edges (divisor is the number of pixels left inside the image).
// one request is handled at a time: store the pixel, then, if the next result's
// window is complete, read the window from the line store one pixel a cycle
// (one ram read port), then run a restoring divide of the sum by the count.
// results appear at most one per request, in raster order; after the frame send
// flush requests (tuser = 1) to drain the delayed bottom rows, tlast marks the
// bottom right pixel, after which a new frame starts. the line store has no
// reset; every entry read is written earlier in the frame. a configuration
// write to index 0 (window), 1 (width) or 2 (height) restarts the frame;
// a write to index 3 is ignored.
module box_mean_filter (
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_in
    input  logic        s_tuser,   // action: 0 pixel, 1 flush
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] mean_out
    output logic        m_tlast,   // frame_last
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    bmf_pkg::bmf_cmd_t  cmd;
    bmf_pkg::bmf_stat_t stat;

    bmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bmf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_action (s_tuser),
        .in_pixel  (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_mean  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

/* rtl/core/bmf_checker.sv */
module bmf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // a result is held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result dropped or changed while stalled");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a result never follows a request in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too soon after request");

    // a result is loaded only while requests are held off
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result loaded while idle");

endmodule

bind box_mean_filter bmf_checker u_bmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* tb/tb_box_mean_filter.sv */
`timescale 1ns / 100ps

// scoreboard: holds the expected means in raster order and checks results
class mean_scoreboard;
    logic [7:0] mean_q[$];
    logic       last_q[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    function void note_request(logic [7:0] mean, logic frame_last);
        mean_q.push_back(mean);
        last_q.push_back(frame_last);
    endfunction

    function void check_result(logic [7:0] mean, logic frame_last);
        logic [7:0] exp_mean;
        logic       exp_last;
        if (mean_q.size() == 0)
        begin
            $error("unexpected result mean_out=%0d frame_last=%0d", mean, frame_last);
            errors++;
            return;
        end
        exp_mean = mean_q.pop_front();
        exp_last = last_q.pop_front();
        if (mean !== exp_mean)
        begin
            $error("mean_out expected %0d actual %0d", exp_mean, mean);
            errors++;
        end
        if (frame_last !== exp_last)
        begin
            $error("frame_last expected %0d actual %0d", exp_last, frame_last);
            errors++;
        end
    endfunction

    function int pending();
        return mean_q.size();
    endfunction
endclass

module tb_box_mean_filter;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] pixel_in
    logic        s_tuser;   // action: 0 pixel, 1 flush
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] mean_out
    logic        m_tlast;   // frame_last
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;
    // index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    box_mean_filter u_top (.*);

    mean_scoreboard sb;

    // predictor state
    logic [7:0] pix_store [bmf_pkg::ROW_SLOTS][bmf_pkg::MAX_WIDTH];
    int unsigned win_reg, wid_reg, hgt_reg;
    int unsigned in_col, in_row, out_col, out_row;
    bit          in_done;

    // idling percentages for each phase
    int unsigned send_idle_pct, recv_stall_pct;
    int          cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // generous limit on the run time, stalls included
    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned clip_radius();
        int unsigned w;
        w = win_reg;
        if (w < 1) w = 1;
        if (w > bmf_pkg::MAX_WINDOW) w = bmf_pkg::MAX_WINDOW;
        return (w - 1) / 2;
    endfunction

    function automatic int unsigned clip_width();
        if (wid_reg < 1) return 1;
        if (wid_reg > bmf_pkg::MAX_WIDTH) return bmf_pkg::MAX_WIDTH;
        return wid_reg;
    endfunction

    function automatic int unsigned clip_height();
        if (hgt_reg < 1) return 1;
        if (hgt_reg > bmf_pkg::MAX_HEIGHT) return bmf_pkg::MAX_HEIGHT;
        return hgt_reg;
    endfunction

    function automatic void restart_frame();
        in_col = 0; in_row = 0; in_done = 0; out_col = 0; out_row = 0;
    endfunction

    // work out the result (if any) caused by one accepted request
    function automatic void predict_mean(logic act, logic [7:0] pix);
        int unsigned wid, hgt, rad, need_r, need_c, r0, c0, total, count;
        bit          ready, last;
        wid = clip_width();
        hgt = clip_height();
        rad = clip_radius();
        if (act == ACT_PIXEL && !in_done)
        begin
            pix_store[in_row % bmf_pkg::ROW_SLOTS][in_col] = pix;
            in_col++;
            if (in_col >= wid)
            begin
                in_col = 0;
                if (in_row + 1 >= hgt) in_done = 1;
                else in_row++;
            end
        end
        need_r = (out_row + rad > hgt - 1) ? hgt - 1 : out_row + rad;
        need_c = (out_col + rad > wid - 1) ? wid - 1 : out_col + rad;
        ready = in_done || in_row > need_r || (in_row == need_r && in_col > need_c);
        if (!ready) return;
        r0 = (out_row >= rad) ? out_row - rad : 0;
        c0 = (out_col >= rad) ? out_col - rad : 0;
        total = 0;
        for (int unsigned r = r0; r <= need_r; r++)
            for (int unsigned c = c0; c <= need_c; c++)
                total += pix_store[r % bmf_pkg::ROW_SLOTS][c];
        count = (need_r - r0 + 1) * (need_c - c0 + 1);
        last = (out_row == hgt - 1) && (out_col == wid - 1);
        sb.note_request(8'(total / count), last);
        if (last)
            restart_frame();
        else
        begin
            out_col++;
            if (out_col >= wid)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    // result side: random stalls, check on every handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // one request, with a random gap first; the block is busy for the
    // cycle after an accepted request, so the closing idle cycle costs nothing
    task automatic send_request(logic act, logic [7:0] pix);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_tready);
        predict_mean(act, pix);
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // drain everything outstanding, then let the block settle
    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            bmf_pkg::REG_WINDOW: win_reg = val & 13'hF;
            bmf_pkg::REG_WIDTH:  wid_reg = val & 13'h7FF;
            bmf_pkg::REG_HEIGHT: hgt_reg = val;
            default:             return;
        endcase
        restart_frame();
    endtask

    task automatic set_frame(int unsigned win, int unsigned w, int unsigned h);
        write_reg(bmf_pkg::REG_WINDOW, 13'(win));
        write_reg(bmf_pkg::REG_WIDTH, 13'(w));
        write_reg(bmf_pkg::REG_HEIGHT, 13'(h));
    endtask

    // a whole frame of random pixels, then flush or spare pixel requests to drain it
    task automatic send_frame(int unsigned style);
        int unsigned npix;
        npix = clip_width() * clip_height();
        for (int unsigned i = 0; i < npix; i++)
        begin
            // a few stray flushes mid-frame
            if ($urandom_range(19) == 0)
                send_request(ACT_FLUSH, 8'($urandom));
            case (style)
                0: send_request(ACT_PIXEL, 8'($urandom));
                1: send_request(ACT_PIXEL, $urandom_range(1) ? 8'hFF : 8'h00);
                default: send_request(ACT_PIXEL, 8'($urandom_range(255, 240)));
            endcase
        end
        while (!(out_row == 0 && out_col == 0 && in_row == 0 && in_col == 0))
            send_request($urandom_range(3) == 0 ? ACT_PIXEL : ACT_FLUSH, 8'($urandom));
    endtask

    int unsigned sent;
    int unsigned w, h, win;

    initial
    begin
        sb = new();
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = ACT_PIXEL;
        cfg_wr_en = 1'b0; cfg_index = bmf_pkg::REG_WINDOW; cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0; cycle_count = 0;
        win_reg = 3; wid_reg = 640; hgt_reg = 480;
        restart_frame();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of sizes and pixel values
        set_frame(1, 1, 1);
        send_request(ACT_FLUSH, 8'h00);   // flush with nothing pending
        send_request(ACT_PIXEL, 8'hFF);
        send_request(ACT_PIXEL, 8'hAA);   // pixel after the last result starts a new frame
        wait_idle();
        set_frame(11, 3, 2);
        send_frame(1);
        wait_idle();
        set_frame(0, 0, 0);               // zero sizes treated as one
        send_request(ACT_PIXEL, 8'h55);
        wait_idle();
        set_frame(4, 5, 3);               // even window acts as the odd one below
        send_frame(2);
        wait_idle();
        set_frame(15, 2, 4);              // window saturates
        send_frame(0);
        wait_idle();
        write_reg(REG_UNUSED, 13'h1FFF);  // unknown index, no restart
        // wide row hits the width ceiling and every column bit
        set_frame(1, 2047, 1);
        send_frame(0);
        wait_idle();
        // restart mid-frame drops pending results
        set_frame(3, 4, 4);
        for (int i = 0; i < 5; i++)
            send_request(ACT_PIXEL, 8'($urandom));
        wait_idle();
        set_frame(3, 4, 4);
        send_frame(0);
        wait_idle();

        // random frames over the idling phases
        sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 3 ? 32 : 60) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 32 : 60) : 0;
            for (int f = 0; f < 3; f++)
            begin
                win = (f == 0) ? 11 : $urandom_range(11, 1);
                w   = (f == 1) ? 1 : $urandom_range(9, 1);
                h   = (f == 2) ? 1 : $urandom_range(9, 1);
                set_frame(win, w, h);
                send_frame($urandom_range(2));
                sent += w * h;
                wait_idle();
            end
        end
        // tall frame: deep row counts, then extreme row and height bits
        send_idle_pct = 0; recv_stall_pct = 20;
        set_frame(11, 2, 4096);
        for (int i = 0; i < 40; i++)
            send_request(ACT_PIXEL, 8'($urandom));
        wait_idle();
        set_frame(5, 1, 8191);            // height saturates to 4096
        for (int i = 0; i < 30; i++)
            send_request(ACT_PIXEL, 8'($urandom));
        wait_idle();
        while (sent < 180)
        begin
            send_idle_pct  = $urandom_range(1) ? 0 : 40;
            recv_stall_pct = $urandom_range(1) ? 0 : 40;
            set_frame($urandom_range(11, 1), $urandom_range(12, 1), $urandom_range(6, 1));
            send_frame($urandom_range(2));
            sent += clip_width() * clip_height();
            wait_idle();
        end

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
